### rtl/esg_pkg.sv
package esg_pkg;

  // default build sizes
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_WIDTH_DEF     = 16;
  localparam int COUNT_WIDTH_DEF      = 24;

  // fixed field widths
  localparam int PHASE_W    = 32;
  localparam int PSTEP_W    = 40;
  localparam int HALF_W     = 20;
  localparam int GROW_W     = 61;
  localparam int ANG_W      = 25;
  localparam int TOTAL_W    = 24;
  localparam int FADE_W     = 16;
  localparam int FSTEP_W    = 24;
  localparam int INDEX_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // register reset values
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 24'd48000;
  localparam logic [FADE_W-1:0]  FADE_RST  = 16'd960;
  localparam logic [FSTEP_W-1:0] FSTEP_RST = 24'd17476;

  // quarter-wave table generation, q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  // quarter turn offset turning a sine lookup into a cosine
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_INC  = 3'd0,
    CFG_GROWTH     = 3'd1,
    CFG_TOTAL      = 3'd2,
    CFG_FADE_LEN   = 3'd3,
    CFG_FADE_STEP  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PSTEP_W-1:0] start_increment;
    logic [PSTEP_W-1:0] growth_minus_one;
    logic [TOTAL_W-1:0] total_samples;
    logic [FADE_W-1:0]  fade_samples;
    logic [FSTEP_W-1:0] fade_step;
  } cfg_t;

  // per-sample conditions seen by the sequencer
  typedef struct packed {
    logic fin_on;
    logic fout_on;
  } cond_t;

  // sequencer states
  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // control word fields
  typedef enum logic [1:0] {
    ROM_NONE,
    ROM_PHASE,
    ROM_FIN,
    ROM_FOUT
  } rom_src_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FIN,
    MUL_FOUT,
    MUL_PL_GL,
    MUL_PH_GL,
    MUL_PL_GH,
    MUL_PH_GH
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_SINE,
    ACC_DIV
  } acc_op_t;

  typedef enum logic [1:0] {
    GR_NONE,
    GR_SET_SHR,
    GR_ADD,
    GR_ADD_SHL
  } grow_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NO_FIN,
    JMP_NO_FOUT
  } jmp_t;

  typedef logic [3:0] uc_addr_t;

  // microprogram step addresses
  localparam uc_addr_t UC_LOOK_SINE = 4'd0;
  localparam uc_addr_t UC_LOAD_SINE = 4'd1;
  localparam uc_addr_t UC_GROW_B    = 4'd2;
  localparam uc_addr_t UC_GROW_C    = 4'd3;
  localparam uc_addr_t UC_FADE_IN   = 4'd4;
  localparam uc_addr_t UC_DIV_IN    = 4'd5;
  localparam uc_addr_t UC_FADE_OUT  = 4'd6;
  localparam uc_addr_t UC_DIV_OUT   = 4'd7;
  localparam uc_addr_t UC_EMIT      = 4'd8;

  typedef struct packed {
    rom_src_t rom_src;
    mul_op_t  mul_op;
    acc_op_t  acc_op;
    grow_op_t grow_op;
    jmp_t     jmp;
    uc_addr_t target;
    logic     last_step;
  } ctrl_t;

  localparam ctrl_t UC_NOP = '{
    rom_src:   ROM_NONE,
    mul_op:    MUL_NONE,
    acc_op:    ACC_NONE,
    grow_op:   GR_NONE,
    jmp:       JMP_NONE,
    target:    UC_LOOK_SINE,
    last_step: 1'b0
  };

  // microprogram: growth products first, then the optional fades
  function automatic ctrl_t ucode(uc_addr_t addr);
    ctrl_t w;
    w = UC_NOP;
    case (addr)
      UC_LOOK_SINE: begin
        w.rom_src = ROM_PHASE;
        w.mul_op  = MUL_PL_GL;
      end
      UC_LOAD_SINE: begin
        w.acc_op  = ACC_SINE;
        w.rom_src = ROM_FIN;
        w.mul_op  = MUL_PH_GL;
        w.grow_op = GR_SET_SHR;
      end
      UC_GROW_B: begin
        w.mul_op  = MUL_PL_GH;
        w.grow_op = GR_ADD;
      end
      UC_GROW_C: begin
        w.mul_op  = MUL_PH_GH;
        w.grow_op = GR_ADD;
      end
      UC_FADE_IN: begin
        w.grow_op = GR_ADD_SHL;
        w.mul_op  = MUL_FIN;
        w.rom_src = ROM_FOUT;
        w.jmp     = JMP_NO_FIN;
        w.target  = UC_FADE_OUT;
      end
      UC_DIV_IN: begin
        w.acc_op = ACC_DIV;
      end
      UC_FADE_OUT: begin
        w.mul_op = MUL_FOUT;
        w.jmp    = JMP_NO_FOUT;
        w.target = UC_EMIT;
      end
      UC_DIV_OUT: begin
        w.acc_op = ACC_DIV;
      end
      UC_EMIT: begin
        w.last_step = 1'b1;
      end
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  // one quarter-wave entry: q30 taylor series, then scaled and rounded half up
  function automatic longint unsigned sine_entry(longint unsigned x, longint unsigned amp);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    return (s * amp + (Q30_ONE >> 1)) >> 30;
  endfunction

endpackage

### rtl/esg_sine_lookup.sv
module esg_sine_lookup #(
  parameter int SINE_TABLE_DEPTH = esg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH     = esg_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [esg_pkg::PHASE_W-1:0]        phase,
  output logic signed [SAMPLE_WIDTH-1:0]     value
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SCL_W = 30 + IDX_W + 1;
  localparam logic [SAMPLE_WIDTH-1:0] AMP = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam longint unsigned AMP_U = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

  // quarter-wave table built at elaboration
  logic [SAMPLE_WIDTH-1:0] rom_w [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam longint unsigned XQ = (esg_pkg::HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
    assign rom_w[i] = SAMPLE_WIDTH'(esg_pkg::sine_entry(XQ, AMP_U));
  end

  // quadrant folding and table index
  logic [1:0]       quad;
  logic [SCL_W-1:0] scaled;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   mirror;
  logic [IDX_W-1:0] addr;
  logic             top;

  assign quad   = phase[31:30];
  assign scaled = SCL_W'(phase[29:0]) * SCL_W'(SINE_TABLE_DEPTH);
  assign idx    = scaled[30 +: IDX_W];
  assign mirror = (IDX_W+1)'(SINE_TABLE_DEPTH) - {1'b0, idx};

  always_comb begin
    if (quad[0]) begin
      top  = (idx == '0);
      addr = top ? '0 : mirror[IDX_W-1:0];
    end else begin
      top  = 1'b0;
      addr = idx;
    end
  end

  // registered table read
  logic [SAMPLE_WIDTH-1:0] rd_r;
  logic                    top_r;
  logic                    neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r  <= rom_w[addr];
      top_r <= top;
      neg_r <= quad[1];
    end
  end

  // full-scale entry past the table end, negated in the upper half turn
  logic [SAMPLE_WIDTH-1:0] mag;

  assign mag   = top_r ? AMP : rd_r;
  assign value = neg_r ? -$signed(mag) : $signed(mag);

endmodule

### rtl/esg_sequencer.sv
module esg_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                stall,
  input  esg_pkg::cond_t      cond,
  output logic                ready,
  output esg_pkg::ctrl_t      ctrl
);

  esg_pkg::seq_state_t state_r, state_nxt;
  esg_pkg::uc_addr_t   step_r, step_nxt;
  esg_pkg::ctrl_t      word;
  logic                taken;

  // control word of the current step
  assign word = esg_pkg::ucode(step_r);

  always_comb begin
    case (word.jmp)
      esg_pkg::JMP_NO_FIN:  taken = !cond.fin_on;
      esg_pkg::JMP_NO_FOUT: taken = !cond.fout_on;
      default:              taken = 1'b0;
    endcase
  end

  // next state and step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      esg_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = esg_pkg::SEQ_RUN;
          step_nxt  = esg_pkg::UC_LOOK_SINE;
        end
      end
      esg_pkg::SEQ_RUN: begin
        if (word.last_step) begin
          if (!stall) begin
            state_nxt = esg_pkg::SEQ_IDLE;
          end
        end else if (taken) begin
          step_nxt = word.target;
        end else begin
          step_nxt = step_r + esg_pkg::uc_addr_t'(1);
        end
      end
      default: state_nxt = esg_pkg::SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready = 1'b0;
    ctrl  = esg_pkg::UC_NOP;
    case (state_r)
      esg_pkg::SEQ_IDLE: ready = 1'b1;
      esg_pkg::SEQ_RUN: begin
        ctrl           = word;
        ctrl.last_step = word.last_step && !stall;
      end
      default: ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esg_pkg::SEQ_IDLE;
      step_r  <= esg_pkg::UC_LOOK_SINE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == esg_pkg::SEQ_RUN |-> step_r <= esg_pkg::UC_EMIT)
    else $error("step counter left the microprogram");

  // a start always enters the program at its first step
  a_start_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esg_pkg::SEQ_IDLE && start) |=>
      (state_r == esg_pkg::SEQ_RUN && step_r == esg_pkg::UC_LOOK_SINE))
    else $error("start did not enter the program at step zero");

  // a fired final step returns to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esg_pkg::SEQ_RUN && ctrl.last_step) |=> state_r == esg_pkg::SEQ_IDLE)
    else $error("sequencer did not return to idle after the final step");

endmodule

### rtl/esg_datapath.sv
module esg_datapath #(
  parameter int SINE_TABLE_DEPTH = esg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH     = esg_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH      = esg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esg_pkg::cfg_t                     cfg,
  input  logic                              accept,
  input  logic                              restart,
  input  esg_pkg::ctrl_t                    ctrl,
  input  logic                              out_ready,
  output esg_pkg::cond_t                    cond,
  output logic                              out_full,
  output logic                              out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
  output logic [esg_pkg::INDEX_W-1:0]       out_index,
  output logic                              out_last
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int K     = SAMPLE_WIDTH - 1;
  localparam int HW    = esg_pkg::HALF_W;
  localparam int MUL_W = (SAMPLE_WIDTH > HW) ? SAMPLE_WIDTH : HW;
  localparam int PRD_W = 2 * MUL_W;
  localparam int CMP_W = (COUNT_WIDTH > esg_pkg::TOTAL_W) ? COUNT_WIDTH : esg_pkg::TOTAL_W;
  localparam int PS_W  = esg_pkg::PSTEP_W;
  localparam int GW    = esg_pkg::GROW_W;
  localparam int AW    = esg_pkg::ANG_W;
  localparam logic [W-1:0] AMP = {1'b0, {(W-1){1'b1}}};

  // sweep state
  logic [esg_pkg::PHASE_W-1:0] phase_r;
  logic [PS_W-1:0]             step_r;
  logic [COUNT_WIDTH-1:0]      count_r;
  logic [AW-1:0]               fin_ang_r;
  logic [AW-1:0]               fout_ang_r;

  // working registers
  logic signed [W-1:0]         acc_r;
  logic [PRD_W-1:0]            prod_r;
  logic                        prod_neg_r;
  logic [GW-1:0]               grow_r;

  // sample position and fade windows
  logic [esg_pkg::TOTAL_W-1:0] total_eff;
  logic [CMP_W-1:0]            n_ext;
  logic                        fades_on;
  logic                        is_last;

  assign total_eff = (cfg.total_samples == '0) ? esg_pkg::TOTAL_W'(1) : cfg.total_samples;
  assign n_ext     = CMP_W'(count_r);
  assign fades_on  = (cfg.fade_samples != '0) &&
                     (esg_pkg::TOTAL_W'(cfg.fade_samples) <= total_eff);
  assign cond.fin_on  = fades_on && (n_ext < CMP_W'(cfg.fade_samples));
  assign cond.fout_on = fades_on &&
                        (n_ext >= CMP_W'(total_eff - esg_pkg::TOTAL_W'(cfg.fade_samples)));
  assign is_last   = n_ext >= CMP_W'(total_eff - esg_pkg::TOTAL_W'(1));

  // table lookup source
  logic [esg_pkg::PHASE_W-1:0] look_phase;
  logic                        look_en;
  logic signed [W-1:0]         look_val;

  always_comb begin
    look_en = 1'b1;
    case (ctrl.rom_src)
      esg_pkg::ROM_PHASE: look_phase = phase_r;
      esg_pkg::ROM_FIN:   look_phase = {fin_ang_r, 7'b0} + esg_pkg::QUARTER_TURN;
      esg_pkg::ROM_FOUT:  look_phase = {fout_ang_r, 7'b0} + esg_pkg::QUARTER_TURN;
      default: begin
        look_phase = phase_r;
        look_en    = 1'b0;
      end
    endcase
  end

  esg_sine_lookup #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH)
  ) u_lookup (
    .clk   (clk),
    .en    (look_en),
    .phase (look_phase),
    .value (look_val)
  );

  // fade gain factors from the cosine
  logic [W-1:0]        mag;
  logic signed [W:0]   cv_x;
  logic signed [W:0]   amp_x;
  logic signed [W:0]   f_in;
  logic signed [W:0]   f_out;

  assign mag   = acc_r[W-1] ? W'(-acc_r) : W'(acc_r);
  assign cv_x  = {look_val[W-1], look_val};
  assign amp_x = $signed({1'b0, AMP});
  assign f_in  = amp_x - cv_x;
  assign f_out = amp_x + cv_x;

  // shared multiplier operands
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic             mul_en;

  always_comb begin
    mul_en = 1'b1;
    case (ctrl.mul_op)
      esg_pkg::MUL_FIN: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(f_in[W-1:0]);
      end
      esg_pkg::MUL_FOUT: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(f_out[W-1:0]);
      end
      esg_pkg::MUL_PL_GL: begin
        mul_a = MUL_W'(step_r[HW-1:0]);
        mul_b = MUL_W'(cfg.growth_minus_one[HW-1:0]);
      end
      esg_pkg::MUL_PH_GL: begin
        mul_a = MUL_W'(step_r[PS_W-1:HW]);
        mul_b = MUL_W'(cfg.growth_minus_one[HW-1:0]);
      end
      esg_pkg::MUL_PL_GH: begin
        mul_a = MUL_W'(step_r[HW-1:0]);
        mul_b = MUL_W'(cfg.growth_minus_one[PS_W-1:HW]);
      end
      esg_pkg::MUL_PH_GH: begin
        mul_a = MUL_W'(step_r[PS_W-1:HW]);
        mul_b = MUL_W'(cfg.growth_minus_one[PS_W-1:HW]);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  // divide by twice full scale: halve, then fold by 2^K-1 twice
  logic [2*K-1:0] dx;
  logic [K-1:0]   da;
  logic [K-1:0]   db;
  logic [K:0]     dab;
  logic [K:0]     dcd;
  logic [K:0]     dq;
  logic signed [W-1:0] q_s;

  assign dx  = prod_r[2*K:1];
  assign da  = dx[2*K-1:K];
  assign db  = dx[K-1:0];
  assign dab = {1'b0, da} + {1'b0, db};
  assign dcd = {{K{1'b0}}, dab[K]} + {1'b0, dab[K-1:0]};
  assign dq  = {1'b0, da} + {{K{1'b0}}, dab[K]} + {{K{1'b0}}, (dcd >= (K+1)'(AMP))};
  assign q_s = $signed(dq);

  // step growth and phase advance for the end of a sample
  logic [2*HW-1:0]  prod_g;
  logic [PS_W:0]    inc;
  logic [PS_W+1:0]  nstep;
  logic [PS_W-1:0]  step_sat;
  logic             end_fire;

  assign prod_g   = prod_r[2*HW-1:0];
  assign inc      = grow_r[GW-1:HW];
  assign nstep    = {2'b0, step_r} + {1'b0, inc};
  assign step_sat = (nstep[PS_W+1:PS_W] != 2'b0) ? {PS_W{1'b1}} : nstep[PS_W-1:0];
  assign end_fire = ctrl.last_step;

  // multiplier, accumulator and growth sum
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r     <= PRD_W'(mul_a) * PRD_W'(mul_b);
      prod_neg_r <= acc_r[W-1];
    end
    case (ctrl.acc_op)
      esg_pkg::ACC_SINE: acc_r <= look_val;
      esg_pkg::ACC_DIV:  acc_r <= prod_neg_r ? -q_s : q_s;
      default:           acc_r <= acc_r;
    endcase
    case (ctrl.grow_op)
      esg_pkg::GR_SET_SHR: grow_r <= GW'(prod_g[2*HW-1:HW]);
      esg_pkg::GR_ADD:     grow_r <= grow_r + GW'(prod_g);
      esg_pkg::GR_ADD_SHL: grow_r <= grow_r + GW'({prod_g, {HW{1'b0}}});
      default:             grow_r <= grow_r;
    endcase
  end

  // sweep state: restart on an accepted restart word, advance or wrap at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      step_r     <= '0;
      count_r    <= '0;
      fin_ang_r  <= '0;
      fout_ang_r <= '0;
    end else if (accept && restart) begin
      phase_r    <= '0;
      step_r     <= cfg.start_increment;
      count_r    <= '0;
      fin_ang_r  <= '0;
      fout_ang_r <= '0;
    end else if (end_fire) begin
      if (is_last) begin
        phase_r    <= '0;
        step_r     <= cfg.start_increment;
        count_r    <= '0;
        fin_ang_r  <= '0;
        fout_ang_r <= '0;
      end else begin
        phase_r <= phase_r + step_r[PS_W-1:8];
        step_r  <= step_sat;
        count_r <= count_r + COUNT_WIDTH'(1);
        if (cond.fin_on) begin
          fin_ang_r <= fin_ang_r + AW'(cfg.fade_step);
        end
        if (cond.fout_on) begin
          fout_ang_r <= fout_ang_r + AW'(cfg.fade_step);
        end
      end
    end
  end

  // output register
  logic                  out_valid_r;
  logic signed [W-1:0]   out_sample_r;
  logic [esg_pkg::INDEX_W-1:0] out_index_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      out_sample_r <= acc_r;
      out_index_r  <= n_ext[esg_pkg::INDEX_W-1:0];
      out_last_r   <= is_last;
    end
  end

  assign out_full   = out_valid_r && !out_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_index  = out_index_r;
  assign out_last   = out_last_r;

  // a finished sample always lands in the output register
  a_end_loads: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> out_valid_r)
    else $error("finished sample not held in the output register");

  // inside a sweep the position moves on by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (end_fire && !is_last) |=> count_r == $past(count_r) + COUNT_WIDTH'(1))
    else $error("sample position did not advance by one");

  // the phase step only grows inside a sweep
  a_step_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (end_fire && !is_last) |=> step_r >= $past(step_r))
    else $error("phase step shrank inside a sweep");

endmodule

### rtl/exponential_sine_sweep_generator_top.sv
// channel  direction  handshake              payload
// in_      slave      in_tvalid / in_tready  tdata: restart
// out_     master     out_tvalid/out_tready  tdata: sample, sample_index; tlast: last
// cfg_     slave      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one sample is an accept, then the microcode steps from table lookup to emit
// on the single table read port and the shared multiplier (fewer steps when no fade applies)
// reset is synchronous: registers take their defaults, the sweep sits at sample zero
// the next word is taken as soon as the sequencer is idle, while a sample waits in
// the output register; the final step holds while that register is still full
module exponential_sine_sweep_generator_top #(
  parameter int SINE_TABLE_DEPTH = esg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH     = esg_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH      = esg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // [0] restart
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH + 24 + 7) / 8) * 8 - 1:0] out_tdata,
                                                 // sample, then sample_index (24)
  output logic                                   out_tlast,  // last
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [esg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [esg_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int OUT_W = ((SAMPLE_WIDTH + 24 + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - SAMPLE_WIDTH - esg_pkg::INDEX_W;

  // configuration registers
  esg_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_increment  <= '0;
      cfg_r.growth_minus_one <= '0;
      cfg_r.total_samples    <= esg_pkg::TOTAL_RST;
      cfg_r.fade_samples     <= esg_pkg::FADE_RST;
      cfg_r.fade_step        <= esg_pkg::FSTEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        esg_pkg::CFG_START_INC: cfg_r.start_increment  <= cfg_data;
        esg_pkg::CFG_GROWTH:    cfg_r.growth_minus_one <= cfg_data;
        esg_pkg::CFG_TOTAL:     cfg_r.total_samples    <= cfg_data[esg_pkg::TOTAL_W-1:0];
        esg_pkg::CFG_FADE_LEN:  cfg_r.fade_samples     <= cfg_data[esg_pkg::FADE_W-1:0];
        esg_pkg::CFG_FADE_STEP: cfg_r.fade_step        <= cfg_data[esg_pkg::FSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  logic                          accept;
  logic                          out_full;
  esg_pkg::cond_t                cond;
  esg_pkg::ctrl_t                ctrl;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [esg_pkg::INDEX_W-1:0]   sample_index;

  assign accept = in_tvalid && in_tready;

  esg_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .stall (out_full),
    .cond  (cond),
    .ready (in_tready),
    .ctrl  (ctrl)
  );

  esg_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .restart    (in_tdata[0]),
    .ctrl       (ctrl),
    .out_ready  (out_tready),
    .cond       (cond),
    .out_full   (out_full),
    .out_valid  (out_tvalid),
    .out_sample (sample),
    .out_index  (sample_index),
    .out_last   (out_tlast)
  );

  // result word packing
  if (PAD_W > 0) begin : g_pad
    assign out_tdata = {{PAD_W{1'b0}}, sample_index, sample};
  end else begin : g_nopad
    assign out_tdata = {sample_index, sample};
  end

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esg_pkg::*;

  typedef longint unsigned u64_t;

  localparam int    SW           = SAMPLE_WIDTH_DEF;
  localparam int    DEPTH        = SINE_TABLE_DEPTH_DEF;
  localparam int    CW           = COUNT_WIDTH_DEF;
  localparam int    OUT_W        = ((SW + 24 + 7) / 8) * 8;
  localparam longint AMPL        = (longint'(1) << (SW - 1)) - 1;
  localparam u64_t  STEP_MAX     = (u64_t'(1) << PSTEP_W) - 1;
  localparam int    SETTLE       = 12;
  localparam int    STALL_LIMIT  = 3000;
  localparam int    RANDOM_WORDS = 1410;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] LAST_SPARE_IDX  = {CFG_IDX_W{1'b1}};

  typedef struct {
    logic [SW-1:0] pcm;
    logic [23:0]   index;
    logic          is_end;
  } sweep_word_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata  = '0;  // [0] restart
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // [SW-1:0] sample, then sample_index (24)
  logic                  out_tlast;       // last
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register shadows
  logic [PSTEP_W-1:0] reg_start, reg_growth;
  logic [TOTAL_W-1:0] reg_total;
  logic [FADE_W-1:0]  reg_fade;
  logic [FSTEP_W-1:0] reg_fade_step;

  // sweep state
  logic [PHASE_W-1:0] sweep_phase;
  u64_t               sweep_step;
  logic [CW-1:0]      sweep_count;
  logic [ANG_W-1:0]   fade_in_ang, fade_out_ang;
  int                 sine_quarter [DEPTH];

  bit          restart_words [$];
  sweep_word_t expected_words [$];

  int src_rate = 0, sink_rate = 0, src_hold = 0, sink_hold = 0;
  int quiet_cycles = 0, mismatches = 0, words_planned = 0, words_sent = 0;
  int samples_checked = 0, sweep_ends = 0, reg_writes = 0, phases = 0;

  exponential_sine_sweep_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // quarter-wave table: q30 odd series, innermost term first, scaled and rounded half up
  task automatic build_sine_table();
    u64_t x, x2, t, s;
    int unsigned series_div [5] = '{110, 72, 42, 20, 6};
    for (int i = 0; i < DEPTH; i++) begin
      x  = (HALF_PI_Q30 * u64_t'(i)) / DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      foreach (series_div[k]) t = Q30_ONE - ((x2 * t) >> 30) / series_div[k];
      s  = (x * t) >> 30;
      sine_quarter[i] = int'((s * u64_t'(AMPL) + (Q30_ONE >> 1)) >> 30);
    end
  endtask

  function automatic longint sine_lookup(input logic [PHASE_W-1:0] ph);
    u64_t   idx;
    longint mag;
    idx = (u64_t'(ph[29:0]) * DEPTH) >> 30;
    if (ph[30]) idx = DEPTH - idx;
    mag = (idx >= DEPTH) ? AMPL : longint'(sine_quarter[idx]);
    return ph[31] ? -mag : mag;
  endfunction

  function automatic longint cosine_of(input logic [ANG_W-1:0] ang);
    return sine_lookup({ang, 7'd0} + QUARTER_TURN);
  endfunction

  task automatic rewind_sweep();
    sweep_phase  = '0;
    sweep_step   = u64_t'(reg_start);
    sweep_count  = '0;
    fade_in_ang  = '0;
    fade_out_ang = '0;
  endtask

  // next windowed sample, then advance phase, step and count, or rewind at the sweep end
  task automatic predict_sample(input bit restart);
    u64_t        span, n, gh, gl, growth_inc, next_step;
    longint      pcm;
    bit          fades_on, at_end;
    sweep_word_t w;
    if (restart) rewind_sweep();
    span     = (reg_total == 0) ? 1 : u64_t'(reg_total);
    n        = u64_t'(sweep_count);
    fades_on = (reg_fade != 0) && (u64_t'(reg_fade) <= span);
    at_end   = (n >= span - 1);
    pcm      = sine_lookup(sweep_phase);
    if (fades_on && n < u64_t'(reg_fade)) begin
      pcm = pcm * (AMPL - cosine_of(fade_in_ang)) / (2 * AMPL);
      fade_in_ang = fade_in_ang + reg_fade_step;
    end
    if (fades_on && n >= span - u64_t'(reg_fade)) begin
      pcm = pcm * (AMPL + cosine_of(fade_out_ang)) / (2 * AMPL);
      fade_out_ang = fade_out_ang + reg_fade_step;
    end
    w.pcm    = pcm[SW-1:0];
    w.index  = n[23:0];
    w.is_end = at_end;
    expected_words.push_back(w);
    if (at_end) begin
      rewind_sweep();
    end else begin
      sweep_phase = sweep_phase + PHASE_W'(sweep_step >> 8);
      gh          = u64_t'(reg_growth) >> HALF_W;
      gl          = u64_t'(reg_growth[HALF_W-1:0]);
      growth_inc  = (sweep_step * gh + ((sweep_step * gl) >> HALF_W)) >> HALF_W;
      next_step   = sweep_step + growth_inc;
      sweep_step  = (next_step > STEP_MAX) ? STEP_MAX : next_step;
      sweep_count = sweep_count + 1'b1;
    end
  endtask

  // one register write; bits above the register width carry junk
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    case (idx)
      CFG_START_INC, CFG_GROWTH: junk = '0;
      CFG_TOTAL, CFG_FADE_STEP:  junk[23:0] = '0;
      CFG_FADE_LEN:              junk[15:0] = '0;
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val | junk;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_INC: reg_start     = val[PSTEP_W-1:0];
      CFG_GROWTH:    reg_growth    = val[PSTEP_W-1:0];
      CFG_TOTAL:     reg_total     = val[TOTAL_W-1:0];
      CFG_FADE_LEN:  reg_fade      = val[FADE_W-1:0];
      CFG_FADE_STEP: reg_fade_step = val[FSTEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // hold until nothing is queued, in flight or awaited
  task automatic wait_drained();
    do @(posedge clk);
    while (restart_words.size() != 0 || in_tvalid || expected_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_words(input int count, input int restart_odds, input bit restart_first);
    for (int k = 0; k < count; k++) begin
      restart_words.push_back((k == 0 && restart_first) ||
                              (restart_odds != 0 && $urandom_range(restart_odds - 1, 0) == 0));
    end
    words_planned += count;
    phases++;
    wait_drained();
  endtask

  task automatic random_phase(input int count, input bit calm);
    logic [PSTEP_W-1:0] wide;
    u64_t               span;
    int                 odds;
    wide = PSTEP_W'({$urandom, $urandom});
    if ($urandom_range(1, 0)) begin
      case ($urandom_range(7, 0))
        0:       write_reg(CFG_START_INC, '0);
        1:       write_reg(CFG_START_INC, STEP_MAX);
        default: write_reg(CFG_START_INC, wide >> $urandom_range(39, 0));
      endcase
    end
    wide = PSTEP_W'({$urandom, $urandom});
    if ($urandom_range(1, 0)) begin
      case ($urandom_range(7, 0))
        0:       write_reg(CFG_GROWTH, '0);
        1:       write_reg(CFG_GROWTH, STEP_MAX);
        default: write_reg(CFG_GROWTH, wide >> $urandom_range(39, 8));
      endcase
    end
    if ($urandom_range(2, 0) != 0) begin
      case ($urandom_range(9, 0))
        0:       write_reg(CFG_TOTAL, '0);
        1:       write_reg(CFG_TOTAL, 1);
        2:       write_reg(CFG_TOTAL, 24'hFF_FFFF);
        3:       write_reg(CFG_TOTAL, $urandom_range(24'hFF_FFFF, 0));
        default: write_reg(CFG_TOTAL, $urandom_range(400, 2));
      endcase
    end
    span = (reg_total == 0) ? 1 : u64_t'(reg_total);
    if ($urandom_range(1, 0)) begin
      case ($urandom_range(7, 0))
        0:       write_reg(CFG_FADE_LEN, '0);
        1:       write_reg(CFG_FADE_LEN, 16'hFFFF);
        2:       write_reg(CFG_FADE_LEN, $urandom_range(16'hFFFF, 0));
        default: write_reg(CFG_FADE_LEN, $urandom_range((span > 65535) ? 65535 : span, 0));
      endcase
    end
    if ($urandom_range(1, 0)) begin
      case ($urandom_range(7, 0))
        0:       write_reg(CFG_FADE_STEP, '0);
        1:       write_reg(CFG_FADE_STEP, 24'hFF_FFFF);
        2:       write_reg(CFG_FADE_STEP, $urandom_range(24'hFF_FFFF, 0));
        default: write_reg(CFG_FADE_STEP, (reg_fade > 1) ? (32'd1 << 24) / reg_fade : 24'hFF_FFFF);
      endcase
    end
    if ($urandom_range(7, 0) == 0)
      write_reg($urandom_range(LAST_SPARE_IDX, FIRST_SPARE_IDX), CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    // idling mix for this phase, none at all near the end
    case ($urandom_range(3, 0))
      0: src_rate = 0;
      1: src_rate = 3;
      2: src_rate = 8;
      default: src_rate = 20;
    endcase
    case ($urandom_range(3, 0))
      0: sink_rate = 0;
      1: sink_rate = 3;
      2: sink_rate = 8;
      default: sink_rate = 20;
    endcase
    if (calm) begin
      src_rate  = 0;
      sink_rate = 0;
    end
    case ($urandom_range(5, 0))
      0:       odds = 0;
      1:       odds = 3;
      default: odds = 40;
    endcase
    send_words(count, odds, $urandom_range(3, 0) == 0);
  endtask

  // source: feeds restart words, with bursts of idling between them
  always @(posedge clk) begin : source
    bit rs;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_sample(in_tdata[0]);
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_hold != 0) begin
          src_hold  <= src_hold - 1;
          in_tvalid <= 1'b0;
        end else if (restart_words.size() != 0 && src_rate != 0 &&
                     $urandom_range(src_rate - 1, 0) == 0) begin
          src_hold  <= $urandom_range(16, 0);
          in_tvalid <= 1'b0;
        end else if (restart_words.size() != 0) begin
          rs = restart_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= 8'(rs);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink: checks each sample word against the oldest prediction
  always @(posedge clk) begin : sink
    sweep_word_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample word: pcm %0d idx %0d end %0b",
                     $signed(out_tdata[SW-1:0]), out_tdata[SW+23:SW], out_tlast);
        end else begin
          w = expected_words.pop_front();
          samples_checked++;
          if (w.is_end) sweep_ends++;
          if (out_tdata[SW-1:0] !== w.pcm || out_tdata[SW+23:SW] !== w.index ||
              out_tlast !== w.is_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample %0d: expected pcm %0d idx %0d end %0b, got pcm %0d idx %0d end %0b",
                       samples_checked, $signed(w.pcm), w.index, w.is_end,
                       $signed(out_tdata[SW-1:0]), out_tdata[SW+23:SW], out_tlast);
          end
        end
      end
      if (sink_hold != 0) begin
        sink_hold  <= sink_hold - 1;
        out_tready <= 1'b0;
      end else if (sink_rate != 0 && $urandom_range(sink_rate - 1, 0) == 0) begin
        sink_hold  <= $urandom_range(16, 0);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d samples outstanding",
               STALL_LIMIT, expected_words.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reg_start     = '0;
    reg_growth    = '0;
    reg_total     = TOTAL_RST;
    reg_fade      = FADE_RST;
    reg_fade_step = FSTEP_RST;
    build_sine_table();
    rewind_sweep();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_rate  = 4;
    sink_rate = 4;

    // reset defaults, then a restart at the top of the sweep
    send_words(1, 0, 1'b0);
    send_words(1, 0, 1'b1);

    // zero length reads as one-sample sweeps; fades off, widest fade step
    write_reg(CFG_START_INC, STEP_MAX);
    write_reg(CFG_GROWTH, STEP_MAX);
    write_reg(CFG_TOTAL, '0);
    write_reg(CFG_FADE_LEN, '0);
    write_reg(CFG_FADE_STEP, 24'hFF_FFFF);
    cfg_valid <= 1'b0;
    send_words(3, 0, 1'b1);

    // longer sweep so the step runs into saturation
    write_reg(CFG_TOTAL, 10);
    cfg_valid <= 1'b0;
    send_words(4, 0, 1'b0);

    // every sample under both fades, a sixteenth of a turn per sample
    write_reg(CFG_START_INC, 40'h10_0000_0000);
    write_reg(CFG_GROWTH, '0);
    write_reg(CFG_TOTAL, 8);
    write_reg(CFG_FADE_LEN, 8);
    write_reg(CFG_FADE_STEP, 24'd2097152);
    cfg_valid <= 1'b0;
    send_words(7, 0, 1'b1);

    // fade longer than the sweep turns fades off; spare index is ignored
    write_reg(CFG_FADE_LEN, 9);
    write_reg(FIRST_SPARE_IDX, CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    send_words(2, 0, 1'b0);

    // sweep shortened beneath the running index
    write_reg(CFG_TOTAL, 16);
    write_reg(CFG_FADE_LEN, 3);
    cfg_valid <= 1'b0;
    send_words(6, 0, 1'b1);
    write_reg(CFG_TOTAL, 4);
    cfg_valid <= 1'b0;
    send_words(2, 0, 1'b0);

    // random settings and restart mixes
    while (words_planned < RANDOM_WORDS) random_phase($urandom_range(110, 30), 1'b0);
    random_phase(40, 1'b1);

    repeat (8) @(posedge clk);
    $display("%0d restart words sent over %0d phases, %0d register writes",
             words_sent, phases, reg_writes);
    $display("%0d samples checked, %0d sweep ends seen, %0d mismatches",
             samples_checked, sweep_ends, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/esg_pkg.sv
rtl/esg_sine_lookup.sv
rtl/esg_sequencer.sv
rtl/esg_datapath.sv
rtl/exponential_sine_sweep_generator_top.sv
test/tb.sv
